/* hw/rtl/psm_pkg.sv */
// psm_pkg: shared types, constants and helpers of the per-stream pattern matcher
// depends on nothing; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package psm_pkg;

  // default number of stream entries in the state memory
  localparam int unsigned STREAMS_DEF = 1024;

  // pattern length in bytes, matched out of the low bytes of the pattern register
  localparam int unsigned PATTERN_BYTES = 7;

  // field widths
  localparam int unsigned SID_W    = 10;
  localparam int unsigned OFFS_W   = 48;
  localparam int unsigned CHUNK_W  = 16;
  localparam int unsigned POS_W    = 3;
  localparam int unsigned PAT_W    = 56;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 56;

  // register reset values
  localparam logic [PAT_W-1:0]   PATTERN_RESET = 56'h41486177394450;
  localparam logic [CHUNK_W-1:0] LIMIT_RESET   = 16'd32768;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_PATTERN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INSPECT_LIMIT = 4'd1;

  // input beat
  typedef struct packed {
    logic [SID_W-1:0] stream_id;
    logic [7:0]       data_byte;
    logic             last_of_chunk;
    logic             new_stream;
  } psm_in_t;

  // result beat
  typedef struct packed {
    logic              match_found;
    logic [OFFS_W-1:0] match_offset;
    logic [POS_W-1:0]  position_after;
    logic              chunk_done;
  } psm_out_t;

  // one stream entry of the state memory
  typedef struct packed {
    logic [POS_W-1:0]   match_position;
    logic [OFFS_W-1:0]  stream_bytes;
    logic [CHUNK_W-1:0] chunk_bytes;
    logic               chunk_stopped;
  } psm_entry_t;

  // stream id modulo a constant entry count, by reciprocal multiplication
  function automatic logic [SID_W-1:0] sid_reduce(logic [SID_W-1:0] sid,
                                                  int unsigned m);
    logic [2*SID_W:0]   recip;
    logic [3*SID_W-1:0] prod;
    logic [SID_W-1:0]   q;
    logic [SID_W-1:0]   mm;
    logic [2*SID_W-1:0] qm;
    if (m >= (1 << SID_W)) begin
      return sid;
    end
    recip = (2*SID_W+1)'(((64'd1 << (2*SID_W)) + 64'(m) - 64'd1) / 64'(m));
    mm    = SID_W'(m);
    prod  = (3*SID_W)'(sid) * (3*SID_W)'(recip);
    q     = prod[3*SID_W-1:2*SID_W];
    qm    = (2*SID_W)'(q) * (2*SID_W)'(mm);
    return sid - qm[SID_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/psm_state_ram.sv */
// psm_state_ram: per-stream state memory, one write port, one registered read port
// depends on psm_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none

module psm_state_ram
  import psm_pkg::*;
#(
  parameter int unsigned DEPTH = STREAMS_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic       clk_i,
  input  wire logic       rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  output psm_entry_t      rd_data_o,
  input  wire logic       wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire psm_entry_t wr_data_i
);

  psm_entry_t mem_q [DEPTH];
  psm_entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* hw/rtl/psm_update.sv */
// psm_update: next state of one stream entry and the result beat for one byte
// depends on psm_pkg for the beat and entry types
`timescale 1ns / 1ps
`default_nettype none

module psm_update
  import psm_pkg::*;
(
  input  wire psm_entry_t          entry_i,
  input  wire psm_in_t             beat_i,
  input  wire logic [PAT_W-1:0]    pattern_i,
  input  wire logic [CHUNK_W-1:0]  limit_i,
  output psm_entry_t               entry_o,
  output psm_out_t                 result_o
);

  logic [POS_W-1:0]  pos;
  logic [POS_W:0]    pos_inc;
  logic [7:0]        pat_cur;
  logic [7:0]        pat_first;
  logic              active;
  logic              found;
  logic [POS_W-1:0]  pos_next;
  logic              stopped_next;
  logic [OFFS_W-1:0] at;

  // stale positions at or past the pattern length count as zero
  assign pos = ({1'b0, entry_i.match_position} >= (POS_W + 1)'(PATTERN_BYTES)) ?
               '0 : entry_i.match_position;

  assign pat_cur   = pattern_i[{pos, 3'b000} +: 8];
  assign pat_first = pattern_i[7:0];
  assign pos_inc   = {1'b0, pos} + (POS_W + 1)'(1);
  assign active    = !entry_i.chunk_stopped && (entry_i.chunk_bytes < limit_i);
  assign at        = entry_i.stream_bytes - OFFS_W'(PATTERN_BYTES - 1);

  // pattern stepping
  always_comb begin
    found        = 1'b0;
    pos_next     = pos;
    stopped_next = entry_i.chunk_stopped;
    if (active) begin
      if (beat_i.data_byte == pat_cur) begin
        if (pos_inc >= (POS_W + 1)'(PATTERN_BYTES)) begin
          found        = 1'b1;
          pos_next     = '0;
          stopped_next = 1'b1;
        end else begin
          pos_next = pos_inc[POS_W-1:0];
        end
      end else begin
        // mismatch may still start a new match
        pos_next = (beat_i.data_byte == pat_first) ? POS_W'(1) : '0;
      end
    end
  end

  // counters and end of chunk
  always_comb begin
    entry_o.match_position = pos_next;
    entry_o.stream_bytes   = entry_i.stream_bytes + OFFS_W'(1);
    entry_o.chunk_bytes    = (&entry_i.chunk_bytes) ? entry_i.chunk_bytes :
                             entry_i.chunk_bytes + CHUNK_W'(1);
    entry_o.chunk_stopped  = stopped_next;
    if (beat_i.last_of_chunk) begin
      entry_o.chunk_bytes   = '0;
      entry_o.chunk_stopped = 1'b0;
    end
  end

  // result beat
  always_comb begin
    result_o.match_found    = found;
    result_o.match_offset   = found ? at : '0;
    result_o.position_after = pos_next;
    result_o.chunk_done     = beat_i.last_of_chunk;
  end

endmodule

`default_nettype wire

/* hw/rtl/per_stream_pattern_matcher_top.sv */
// per_stream_pattern_matcher_top: one byte per cycle unless stalled, registered result
// throughput 1 beat/cycle unless stalled, set by the state RAM read-modify-write
// with a one-entry write-back forward between consecutive beats of the same stream
// reset: registers take their reset values, then a clearing pass zeroes the state RAM
// one entry a cycle, all STREAMS entries, while in_stall_o is high
// depends on psm_pkg, psm_state_ram, psm_update
`timescale 1ns / 1ps
`default_nettype none

module per_stream_pattern_matcher_top
  import psm_pkg::*;
#(
  parameter int unsigned STREAMS = STREAMS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire psm_in_t              in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output psm_out_t                  out_data_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int unsigned AW = (STREAMS > 1) ? $clog2(STREAMS) : 1;

  logic [PAT_W-1:0]   pattern_q;
  logic [CHUNK_W-1:0] limit_q;

  logic          clearing_q;
  logic [AW-1:0] clr_q;

  logic          adv;
  logic          in_acc;

  logic          s1_valid_q;
  logic [AW-1:0] s1_idx_q;
  psm_in_t       s1_beat_q;

  logic          s2_valid_q;
  logic [AW-1:0] s2_idx_q;
  psm_in_t       s2_beat_q;

  logic          fwd_valid_q;
  logic [AW-1:0] fwd_idx_q;
  psm_entry_t    fwd_data_q;

  psm_entry_t    rd_data;
  psm_entry_t    cur_entry;
  psm_entry_t    new_entry;
  psm_out_t      result;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  psm_entry_t    wr_data;

  logic          out_valid_q;
  psm_out_t      out_data_q;

  // configuration registers, to be written only while idle by the user; the block does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= PATTERN_RESET;
      limit_q   <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MATCH_PATTERN: pattern_q <= cfg_data_i[PAT_W-1:0];
        CFG_INSPECT_LIMIT: limit_q   <= cfg_data_i[CHUNK_W-1:0];
        default: ;
      endcase
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      if (clr_q == AW'(STREAMS - 1)) begin
        clearing_q <= 1'b0;
      end
      clr_q <= clr_q + AW'(1);
    end
  end

  // the whole pipe moves when the output register can take a beat
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = clearing_q || !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // stage 1: stream index reduced to an entry address, RAM read issued from here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_idx_q  <= AW'(sid_reduce(in_data_i.stream_id, STREAMS));
      s1_beat_q <= in_data_i;
    end
  end

  // stage 2: entry data arrives from the RAM
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_idx_q  <= s1_idx_q;
      s2_beat_q <= s1_beat_q;
    end
  end

  psm_state_ram #(
    .DEPTH (STREAMS),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (adv),
    .rd_addr_i (s1_idx_q),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // forward the write made on the edge of this beat's read, fresh streams start at zero
  always_comb begin
    if (s2_beat_q.new_stream) begin
      cur_entry = '0;
    end else if (fwd_valid_q && (fwd_idx_q == s2_idx_q)) begin
      cur_entry = fwd_data_q;
    end else begin
      cur_entry = rd_data;
    end
  end

  psm_update u_update (
    .entry_i   (cur_entry),
    .beat_i    (s2_beat_q),
    .pattern_i (pattern_q),
    .limit_i   (limit_q),
    .entry_o   (new_entry),
    .result_o  (result)
  );

  // write-back, or zeroes during the clearing pass
  always_comb begin
    if (clearing_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_q;
      wr_data = '0;
    end else begin
      wr_en   = adv && s2_valid_q;
      wr_addr = s2_idx_q;
      wr_data = new_entry;
    end
  end

  // last write-back, kept for the beat behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (adv && s2_valid_q && !clearing_q) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      fwd_idx_q  <= s2_idx_q;
      fwd_data_q <= new_entry;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s2_valid_q) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // no beat enters the pipe while the state RAM is being cleared
  a_no_accept_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !in_acc && !s1_valid_q && !s2_valid_q)
    else $error("beat in flight during clearing pass");

  // the clearing pass ends only after the last entry
  a_clear_complete : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> $past(clr_q) == AW'(STREAMS - 1))
    else $error("clearing pass ended early");

  // a completed match always restarts the pattern
  a_match_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.match_found) |-> out_data_o.position_after == '0)
    else $error("match reported with nonzero position");

  // an accepted beat moves into stage 1 on the same edge
  a_accept_stage1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted beat lost before stage 1");

endmodule

`default_nettype wire

/* verif/per_stream_pattern_matcher_top_tb.sv */
// per_stream_pattern_matcher_top_tb: self-checking bench for the per-stream pattern matcher
// keeps its own per-stream match state to predict every result beat, with random idling
// depends on psm_pkg and per_stream_pattern_matcher_top
`timescale 1ns / 1ps

module per_stream_pattern_matcher_top_tb;
  import psm_pkg::*;

  localparam int unsigned STREAM_CNT = STREAMS_DEF;
  localparam int unsigned CYCLE_CAP  = 400000;
  // index past the register list, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'hF;

  logic                 clk = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  psm_in_t              in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  psm_out_t             out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  // predicted registers and per-stream state
  logic [PAT_W-1:0]   pat_reg;
  logic [CHUNK_W-1:0] lim_reg;
  logic [POS_W-1:0]   stream_pos  [STREAM_CNT];
  logic [OFFS_W-1:0]  stream_offs [STREAM_CNT];
  logic [CHUNK_W-1:0] chunk_cnt   [STREAM_CNT];
  logic               chunk_stop  [STREAM_CNT];

  psm_out_t match_reports[$];
  int       mismatches = 0;
  int       result_no  = 0;
  int       cycle_cnt  = 0;
  bit       jitter_on  = 1'b1;

  per_stream_pattern_matcher_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_CAP) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // random receiver stalls
  always @(posedge clk) begin
    out_stall_i <= jitter_on && ($urandom_range(99) < 16);
  end

  function automatic logic [7:0] pat_at(int k);
    return pat_reg[8*k +: 8];
  endfunction

  // advance one stream by one byte and return the beat it must produce
  function automatic psm_out_t scan_byte(psm_in_t b);
    int unsigned       s;
    logic [POS_W-1:0]  p;
    logic [OFFS_W-1:0] here;
    psm_out_t          r;
    s = b.stream_id % STREAM_CNT;
    r = '0;
    if (b.new_stream) begin
      stream_pos[s]  = '0;
      stream_offs[s] = '0;
      chunk_cnt[s]   = '0;
      chunk_stop[s]  = 1'b0;
    end
    p = stream_pos[s];
    if (p >= PATTERN_BYTES) p = '0;
    here = stream_offs[s];
    if (!chunk_stop[s] && chunk_cnt[s] < lim_reg) begin
      if (b.data_byte == pat_at(p)) begin
        p = p + 1'b1;
        if (p >= PATTERN_BYTES) begin
          r.match_found  = 1'b1;
          r.match_offset = here - OFFS_W'(PATTERN_BYTES - 1);
          p = '0;
          chunk_stop[s] = 1'b1;
        end
      end else begin
        p = (b.data_byte == pat_at(0)) ? 3'd1 : 3'd0;
      end
    end
    stream_pos[s]  = p;
    stream_offs[s] = here + 1'b1;
    if (chunk_cnt[s] != '1) chunk_cnt[s] = chunk_cnt[s] + 1'b1;
    if (b.last_of_chunk) begin
      chunk_cnt[s]  = '0;
      chunk_stop[s] = 1'b0;
    end
    r.position_after = p;
    r.chunk_done     = b.last_of_chunk;
    return r;
  endfunction

  // byte that mostly continues the stream's partial match
  function automatic logic [7:0] steer_byte(logic [SID_W-1:0] sid);
    logic [POS_W-1:0] p;
    int unsigned      r;
    p = stream_pos[sid % STREAM_CNT];
    if (p >= PATTERN_BYTES) p = '0;
    r = $urandom_range(99);
    if (r < 65) return pat_at(p);
    if (r < 75) return pat_at(0);
    return 8'($urandom);
  endfunction

  // send one byte beat, predict its result once accepted
  task automatic send_byte(input logic [SID_W-1:0] sid, input logic [7:0] data,
                           input bit last, input bit fresh);
    psm_in_t b;
    b.stream_id     = sid;
    b.data_byte     = data;
    b.last_of_chunk = last;
    b.new_stream    = fresh;
    cfg_valid_i <= 1'b0;
    while (jitter_on && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk);
    while (in_stall_o !== 1'b0) @(posedge clk);
    match_reports.push_back(scan_byte(b));
  endtask

  task automatic send_pattern(input logic [SID_W-1:0] sid, input bit last);
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      send_byte(sid, pat_at(k), last && (k == PATTERN_BYTES - 1), 1'b0);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk);
    while (cfg_ready_o !== 1'b1) @(posedge clk);
    if (idx == CFG_MATCH_PATTERN) pat_reg = d[PAT_W-1:0];
    else if (idx == CFG_INSPECT_LIMIT) lim_reg = d[CHUNK_W-1:0];
  endtask

  // limit write with random upper bits that must be ignored
  task automatic write_limit(input logic [CHUNK_W-1:0] lim);
    logic [63:0] noise;
    noise = {$urandom, $urandom};
    write_reg(CFG_INSPECT_LIMIT, {noise[CFG_DAT_W-CHUNK_W-1:0], lim});
  endtask

  // drain all pending results, then let the pipeline empty
  task automatic settle();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    @(posedge clk);
    while (match_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic flag_field(input string what, input logic [63:0] want,
                            input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("result %0d %s: expected %0h, got %0h", result_no, what, want, got);
    end
  endtask

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin : check_results
    psm_out_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (match_reports.size() == 0) begin
        flag_field("beat with no prediction", 64'd0, 64'(out_data_o));
      end else begin
        want = match_reports.pop_front();
        if (out_data_o.match_found !== want.match_found)
          flag_field("match_found", 64'(want.match_found), 64'(out_data_o.match_found));
        if (out_data_o.match_offset !== want.match_offset)
          flag_field("match_offset", 64'(want.match_offset), 64'(out_data_o.match_offset));
        if (out_data_o.position_after !== want.position_after)
          flag_field("position_after", 64'(want.position_after),
                     64'(out_data_o.position_after));
        if (out_data_o.chunk_done !== want.chunk_done)
          flag_field("chunk_done", 64'(want.chunk_done), 64'(out_data_o.chunk_done));
      end
      result_no++;
    end
  end

  // reset pattern: plain match, stopped chunk, restart on first byte, stream clear
  task automatic test_default_pattern();
    send_pattern(10'd0, 1'b0);
    send_byte(10'd0, pat_at(0), 1'b0, 1'b0);
    send_byte(10'd0, 8'h00, 1'b1, 1'b0);
    send_byte(10'd1023, pat_at(0), 1'b0, 1'b0);
    send_byte(10'd1023, pat_at(1), 1'b0, 1'b0);
    send_byte(10'd1023, pat_at(0), 1'b0, 1'b0);
    for (int k = 1; k < PATTERN_BYTES; k++) begin
      send_byte(10'd1023, pat_at(k), k == PATTERN_BYTES - 1, 1'b0);
    end
    send_byte(10'd5, pat_at(0), 1'b0, 1'b0);
    send_byte(10'd5, pat_at(1), 1'b0, 1'b0);
    send_byte(10'd5, pat_at(2), 1'b0, 1'b0);
    send_byte(10'd5, pat_at(3), 1'b0, 1'b1);
    send_byte(10'd5, 8'hFF, 1'b1, 1'b1);
  endtask

  // spare index, zero limit, small limit, all-ones registers
  task automatic test_config_edges();
    settle();
    write_reg(CFG_SPARE_IDX, '1);
    send_pattern(10'd2, 1'b1);
    settle();
    write_limit(16'd0);
    send_pattern(10'd3, 1'b1);
    settle();
    write_reg(CFG_MATCH_PATTERN, '1);
    write_limit(16'd3);
    repeat (8) send_byte(10'd4, 8'hFF, 1'b0, 1'b0);
    send_byte(10'd4, 8'hFF, 1'b1, 1'b0);
    settle();
    write_reg(CFG_INSPECT_LIMIT, '1);
    repeat (PATTERN_BYTES) send_byte(10'd4, 8'hFF, 1'b0, 1'b0);
    send_byte(10'd4, 8'hFF, 1'b1, 1'b0);
  endtask

  // limit equal to the pattern length still matches, one byte less does not
  task automatic test_limit_boundary();
    settle();
    write_limit(16'(PATTERN_BYTES));
    send_pattern(10'd9, 1'b1);
    settle();
    write_limit(16'(PATTERN_BYTES - 1));
    send_pattern(10'd9, 1'b1);
  endtask

  task automatic run_random_phase(input logic [PAT_W-1:0] pat, input logic [CHUNK_W-1:0] lim,
                                  input bit calm, input int n);
    logic [SID_W-1:0] pool[4];
    logic [SID_W-1:0] sid;
    settle();
    write_reg(CFG_MATCH_PATTERN, pat);
    write_limit(lim);
    jitter_on = !calm;
    pool[0] = '0;
    pool[1] = '1;
    pool[2] = SID_W'($urandom);
    pool[3] = SID_W'($urandom);
    for (int i = 0; i < n; i++) begin
      // mostly a few busy streams, now and then a stray one
      if ($urandom_range(99) < 85) sid = pool[$urandom_range(3)];
      else sid = SID_W'($urandom);
      send_byte(sid, steer_byte(sid), $urandom_range(99) < 8, $urandom_range(99) < 3);
    end
    jitter_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [PAT_W-1:0] pat;
    pat = PAT_W'({$urandom, $urandom});
    run_random_phase(pat, 16'hFFFF, 1'b0, 120);
    run_random_phase('0, 16'($urandom_range(4, 20)), 1'b0, 120);
    pat = PAT_W'({$urandom, $urandom});
    pat[15:8] = pat[7:0];
    run_random_phase(pat, LIMIT_RESET, 1'b1, 120);
    run_random_phase('1, 16'd1, 1'b0, 120);
    run_random_phase(PATTERN_RESET, LIMIT_RESET, 1'b0, 120);
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    pat_reg = PATTERN_RESET;
    lim_reg = LIMIT_RESET;
    for (int s = 0; s < STREAM_CNT; s++) begin
      stream_pos[s]  = '0;
      stream_offs[s] = '0;
      chunk_cnt[s]   = '0;
      chunk_stop[s]  = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    // wait out the state clearing pass
    @(posedge clk);
    while (in_stall_o !== 1'b0) @(posedge clk);
    test_default_pattern();
    test_config_edges();
    test_limit_boundary();
    test_random_traffic();
    settle();
    if (mismatches == 0 && match_reports.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
